FILE: sv/lpc_pkg.sv
package lpc_pkg;

  // Number of CORDIC cells in each of the two vectoring chains and the rotation chain.
  localparam int CORDIC_STAGES = 24;

  // Datapath widths of the CORDIC cells and the square-root cells.
  localparam int CW      = 56;
  localparam int ZW      = 34;
  localparam int SQ_W    = 64;
  localparam int SQ_STEPS = 32;

  // Configuration port index width.
  localparam int CFG_IDX_W = 2;

  // Fixed-point constants.
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] INV_K       = 32'd2608131496;
  localparam logic [31:0] INV_K2      = 32'd1583795506;
  localparam logic [52:0] MAX_GAMMA   = 53'h10_0000_0000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INDUCTANCE  = 2'd0,
    REG_CAPACITANCE = 2'd1,
    REG_CONDUCTANCE = 2'd2
  } cfg_reg_t;

  // Vector handed along a CORDIC chain.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // Partial remainder and root handed along the square-root chain.
  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } isqrt_t;

  // Side information that travels alongside the vectoring chains.
  typedef struct packed {
    logic signed [6:0] sz;
    logic signed [6:0] sy;
    logic              zr;
    logic              zg;
  } vec_side_t;

  // Side information that travels alongside the square-root chain.
  typedef struct packed {
    logic signed [6:0]  h;
    logic               nz;
    logic signed [ZW:0] tsum;
  } isq_side_t;

  // Arctangent of 2^-k in Q2.30 radians.
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] k);
    logic [31:0] a;
    unique case (k)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      5'd24: a = 32'h0000003F;
      5'd25: a = 32'h0000001F;
      5'd26: a = 32'h0000000F;
      5'd27: a = 32'h00000008;
      5'd28: a = 32'h00000004;
      5'd29: a = 32'h00000002;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return $signed(ZW'(a));
  endfunction

  // Bit length of a word: position of the highest set bit plus one, zero for zero.
  function automatic logic [5:0] bit_len(input logic [51:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 52; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  // Shift a component so that the larger one of its pair lies in [2^29, 2^30).
  function automatic logic [29:0] norm30(input logic [51:0] v, input logic [5:0] len);
    logic signed [6:0] s;
    logic [51:0]       t;
    s = $signed({1'b0, len}) - 7'sd30;
    if (!s[6]) t = v >> s[5:0];
    else       t = v << 6'(-s);
    return t[29:0];
  endfunction

endpackage

FILE: sv/lpc_cordic_cell.sv
module lpc_cordic_cell (
  input  logic              clk,
  input  logic              rotate,
  input  logic [4:0]        shift,
  input  lpc_pkg::cordic_t  d,
  output lpc_pkg::cordic_t  q
);

  logic signed [lpc_pkg::CW-1:0] dx;
  logic signed [lpc_pkg::CW-1:0] dy;
  logic signed [lpc_pkg::ZW-1:0] ang;
  logic                          up;
  lpc_pkg::cordic_t              q_next;

  // One micro-rotation: vectoring steers on the sign of y, rotation on the sign of z.
  always_comb begin
    dx  = d.y >>> shift;
    dy  = d.x >>> shift;
    ang = lpc_pkg::atan_q30(shift);
    up  = rotate ? d.z[lpc_pkg::ZW-1] : !d.y[lpc_pkg::CW-1];
    if (up) begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + ang;
    end else begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: sv/lpc_isqrt_cell.sv
module lpc_isqrt_cell (
  input  logic                     clk,
  input  logic [lpc_pkg::SQ_W-1:0] bit_val,
  input  lpc_pkg::isqrt_t          d,
  output lpc_pkg::isqrt_t          q
);

  logic [lpc_pkg::SQ_W-1:0] trial;
  lpc_pkg::isqrt_t          q_next;

  // One restoring digit of the square root.
  always_comb begin
    trial = d.root + bit_val;
    if (d.rem >= trial) begin
      q_next.rem  = d.rem - trial;
      q_next.root = (d.root >> 1) + bit_val;
    end else begin
      q_next.rem  = d.rem;
      q_next.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: sv/line_propagation_constant.sv
// Channel      Signals                                             Direction
// command      start, busy, frequency_hz, series_resistance,
//              extra_reactance                                     in (busy out)
// result       done, attenuation, phase_constant, saturated        out
// config       cfg_valid, cfg_ready, cfg_index, cfg_data           in (cfg_ready out)
//
// A new command transaction is taken in every cycle while busy is low; busy is high during reset and
// for the first cycle after it.
// Latency is set by the two CORDIC chains in series and the 32-cell square-root
// chain; every stage advances each cycle.
// Reset clears the configuration registers and all in-flight transactions.
// Results are presented for one cycle with done; the receiver cannot stall.
module line_propagation_constant (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   frequency_hz,
  input  logic [31:0]                   series_resistance,
  input  logic [31:0]                   extra_reactance,
  output logic                          done,
  output logic [31:0]                   attenuation,
  output logic [31:0]                   phase_constant,
  output logic                          saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int N   = lpc_pkg::CORDIC_STAGES;
  localparam int SQN = lpc_pkg::SQ_STEPS;
  localparam int LAT = 46 + 2 * N;
  localparam int V8  = 7 + N;

  logic [31:0] inductance_per_metre;
  logic [31:0] capacitance_per_metre;
  logic [31:0] conductance_per_metre;
  logic [LAT-1:0] vld;

  // Configuration registers; writes to an unknown index are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inductance_per_metre  <= '0;
      capacitance_per_metre <= '0;
      conductance_per_metre <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpc_pkg::REG_INDUCTANCE:  inductance_per_metre  <= cfg_data;
        lpc_pkg::REG_CAPACITANCE: capacitance_per_metre <= cfg_data;
        lpc_pkg::REG_CONDUCTANCE: conductance_per_metre <= cfg_data;
        default: ;
      endcase
    end
  end

  // Busy during reset and for one cycle after; the valid line follows every transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAT-2:0], start & ~busy};
    end
  end

  // Stage 1: capture the command and the line constants.
  logic [31:0] f1, r1, xi1, l1, c1, g1;
  always_ff @(posedge clk) begin
    f1  <= frequency_hz;
    r1  <= series_resistance;
    xi1 <= extra_reactance;
    l1  <= inductance_per_metre;
    c1  <= capacitance_per_metre;
    g1  <= conductance_per_metre;
  end

  // Stage 2: frequency times inductance and capacitance.
  logic [63:0] pl2, pc2;
  logic [31:0] r2, xi2, g2;
  always_ff @(posedge clk) begin
    pl2 <= 64'(f1) * 64'(l1);
    pc2 <= 64'(f1) * 64'(c1);
    r2  <= r1;
    xi2 <= xi1;
    g2  <= g1;
  end

  // Stage 3: partial products with pi.
  logic [63:0] lh3, ll3, ch3, cl3;
  logic [31:0] r3, xi3, g3;
  always_ff @(posedge clk) begin
    lh3 <= 64'(pl2[63:32]) * 64'(lpc_pkg::PI_Q30);
    ll3 <= 64'(pl2[31:0]) * 64'(lpc_pkg::PI_Q30);
    ch3 <= 64'(pc2[63:32]) * 64'(lpc_pkg::PI_Q30);
    cl3 <= 64'(pc2[31:0]) * 64'(lpc_pkg::PI_Q30);
    r3  <= r2;
    xi3 <= xi2;
    g3  <= g2;
  end

  // Stage 4: series reactance and shunt susceptance.
  logic [64:0] lsum, csum;
  logic [44:0] xs4;
  logic [51:0] bs4;
  logic [31:0] r4, g4;
  always_comb begin
    lsum = {1'b0, lh3} + 65'(ll3[63:32]);
    csum = {1'b0, ch3} + 65'(cl3[63:32]);
  end

  always_ff @(posedge clk) begin
    xs4 <= 45'(lsum >> 21) + 45'(xi3);
    bs4 <= 52'(csum >> 13);
    r4  <= r3;
    g4  <= g3;
  end

  // Stage 5: bit length of the larger component of each pair.
  logic [5:0]  lz5, ly5;
  logic [51:0] zr5, zi5, yr5, yi5;
  always_ff @(posedge clk) begin
    lz5 <= lpc_pkg::bit_len(52'(r4) | 52'(xs4));
    ly5 <= lpc_pkg::bit_len(52'(g4) | bs4);
    zr5 <= 52'(r4);
    zi5 <= 52'(xs4);
    yr5 <= 52'(g4);
    yi5 <= bs4;
  end

  // Stage 6: normalise both pairs into the CORDIC range; the side information
  // moves along beside the vectoring cells, one entry per cell.
  lpc_pkg::cordic_t  vz_c [N+1];
  lpc_pkg::cordic_t  vy_c [N+1];
  lpc_pkg::vec_side_t vside [N+1];
  always_ff @(posedge clk) begin
    vz_c[0].x <= $signed(lpc_pkg::CW'(lpc_pkg::norm30(zr5, lz5)));
    vz_c[0].y <= $signed(lpc_pkg::CW'(lpc_pkg::norm30(zi5, lz5)));
    vz_c[0].z <= '0;
    vy_c[0].x <= $signed(lpc_pkg::CW'(lpc_pkg::norm30(yr5, ly5)));
    vy_c[0].y <= $signed(lpc_pkg::CW'(lpc_pkg::norm30(yi5, ly5)));
    vy_c[0].z <= '0;
    vside[0].sz <= $signed({1'b0, lz5}) - 7'sd30;
    vside[0].sy <= $signed({1'b0, ly5}) - 7'sd30;
    vside[0].zr <= (zr5 == '0);
    vside[0].zg <= (yr5 == '0);
    for (int j = 1; j <= N; j++) begin
      vside[j] <= vside[j-1];
    end
  end

  // Vectoring chains for the series and shunt factors.
  for (genvar j = 0; j < N; j++) begin : g_vec
    lpc_cordic_cell u_vz (
      .clk    (clk),
      .rotate (1'b0),
      .shift  (5'(j % 32)),
      .d      (vz_c[j]),
      .q      (vz_c[j+1])
    );
    lpc_cordic_cell u_vy (
      .clk    (clk),
      .rotate (1'b0),
      .shift  (5'(j % 32)),
      .d      (vy_c[j]),
      .q      (vy_c[j+1])
    );
  end

  // Stage 7: magnitudes and angles of both factors.
  logic [31:0]                   mz7, my7;
  logic signed [lpc_pkg::ZW-1:0] tz7, ty7;
  logic signed [7:0]             e7;
  always_ff @(posedge clk) begin
    mz7 <= (!vz_c[N].x[lpc_pkg::CW-1] && vz_c[N].x != '0) ? vz_c[N].x[31:0] : '0;
    my7 <= (!vy_c[N].x[lpc_pkg::CW-1] && vy_c[N].x != '0) ? vy_c[N].x[31:0] : '0;
    tz7 <= vside[N].zr ? $signed(lpc_pkg::ZW'(lpc_pkg::HALF_PI_Q30)) : vz_c[N].z;
    ty7 <= vside[N].zg ? $signed(lpc_pkg::ZW'(lpc_pkg::HALF_PI_Q30)) : vy_c[N].z;
    e7  <= 8'(vside[N].sz) + 8'(vside[N].sy) - 8'sd24;
  end

  // Stage 8: product of magnitudes and sum of angles.
  logic [63:0]                 mp8;
  logic signed [lpc_pkg::ZW:0] ts8;
  logic                        nz8;
  logic signed [7:0]           e8;
  always_ff @(posedge clk) begin
    mp8 <= 64'(mz7) * 64'(my7);
    ts8 <= (lpc_pkg::ZW+1)'(tz7) + (lpc_pkg::ZW+1)'(ty7);
    nz8 <= (mz7 != '0) && (my7 != '0);
    e8  <= e7;
  end

  // Stage 9: partial products with the squared gain correction.
  logic [63:0]                 mh9, ml9;
  logic signed [lpc_pkg::ZW:0] ts9;
  logic                        nz9;
  logic signed [7:0]           e9;
  always_ff @(posedge clk) begin
    mh9 <= 64'(mp8[63:32]) * 64'(lpc_pkg::INV_K2);
    ml9 <= 64'(mp8[31:0]) * 64'(lpc_pkg::INV_K2);
    ts9 <= ts8;
    nz9 <= nz8;
    e9  <= e8;
  end

  // Stage 10: radicand, made even in exponent.
  logic [63:0]        mm10;
  logic signed [7:0]  ee10;
  lpc_pkg::isqrt_t    sq_c [SQN+1];
  lpc_pkg::isq_side_t iside [SQN+1];
  always_comb begin
    mm10 = mh9 + 64'(ml9[63:32]);
    ee10 = e9;
    if (e9[0]) begin
      mm10 = mm10 << 1;
      ee10 = e9 - 8'sd1;
    end
  end

  // The side information moves along beside the square-root cells.
  always_ff @(posedge clk) begin
    sq_c[0].rem    <= mm10;
    sq_c[0].root   <= '0;
    iside[0].h     <= 7'(ee10 >>> 1);
    iside[0].nz    <= nz9;
    iside[0].tsum  <= ts9;
    for (int j = 1; j <= SQN; j++) begin
      iside[j] <= iside[j-1];
    end
  end

  // Square-root chain, one result bit per cell.
  for (genvar j = 0; j < SQN; j++) begin : g_sq
    lpc_isqrt_cell u_sq (
      .clk     (clk),
      .bit_val (lpc_pkg::SQ_W'(1) << (lpc_pkg::SQ_W - 2 - 2 * j)),
      .d       (sq_c[j]),
      .q       (sq_c[j+1])
    );
  end

  // Stage 11: apply the exponent and cap gamma.
  logic [63:0]                 gsh;
  logic [6:0]                  hneg;
  logic [52:0]                 gm11;
  logic signed [lpc_pkg::ZW:0] ts11;
  always_comb begin
    hneg = 7'(-iside[SQN].h);
    if (!iside[SQN].h[6])  gsh = 64'(sq_c[SQN].root[31:0]) << iside[SQN].h[5:0];
    else if (!hneg[6])     gsh = 64'(sq_c[SQN].root[31:0]) >> hneg[5:0];
    else                   gsh = '0;
  end

  always_ff @(posedge clk) begin
    if (!iside[SQN].nz)         gm11 <= '0;
    else if (gsh > 64'(lpc_pkg::MAX_GAMMA)) gm11 <= lpc_pkg::MAX_GAMMA;
    else                        gm11 <= gsh[52:0];
    ts11 <= iside[SQN].tsum;
  end

  // Stage 12: pre-scale for the rotation gain.
  logic [63:0]                 gh12, gl12;
  logic signed [lpc_pkg::ZW:0] ts12;
  always_ff @(posedge clk) begin
    gh12 <= 64'(gm11[52:32]) * 64'(lpc_pkg::INV_K);
    gl12 <= 64'(gm11[31:0]) * 64'(lpc_pkg::INV_K);
    ts12 <= ts11;
  end

  // Stage 13: start vector of the rotation through the mean angle.
  lpc_pkg::cordic_t rot_c [N+1];
  logic [63:0]      x0;
  logic signed [lpc_pkg::ZW:0] zh;
  always_comb begin
    x0 = gh12 + 64'(gl12[63:32]);
    zh = ts12 >>> 1;
  end

  always_ff @(posedge clk) begin
    rot_c[0].x <= $signed(lpc_pkg::CW'(x0));
    rot_c[0].y <= '0;
    rot_c[0].z <= zh[lpc_pkg::ZW-1:0];
  end

  // Rotation chain.
  for (genvar j = 0; j < N; j++) begin : g_rot
    lpc_cordic_cell u_rot (
      .clk    (clk),
      .rotate (1'b1),
      .shift  (5'(j % 32)),
      .d      (rot_c[j]),
      .q      (rot_c[j+1])
    );
  end

  // Stage 14: clip to the output range and present the result.
  logic                          sat_a, sat_b;
  logic [31:0]                   a_next, b_next;
  logic signed [lpc_pkg::CW-1:0] ra, rb;
  always_comb begin
    ra = rot_c[N].x;
    rb = rot_c[N].y;
    sat_a = 1'b0;
    sat_b = 1'b0;
    if (ra[lpc_pkg::CW-1] || ra == '0) begin
      a_next = '0;
    end else if (ra[lpc_pkg::CW-2:32] != '0) begin
      a_next = '1;
      sat_a  = 1'b1;
    end else begin
      a_next = ra[31:0];
    end
    if (rb[lpc_pkg::CW-1] || rb == '0) begin
      b_next = '0;
    end else if (rb[lpc_pkg::CW-2:32] != '0) begin
      b_next = '1;
      sat_b  = 1'b1;
    end else begin
      b_next = rb[31:0];
    end
  end

  always_ff @(posedge clk) begin
    attenuation    <= a_next;
    phase_constant <= b_next;
    saturated      <= sat_a | sat_b;
  end

  assign done = vld[LAT-1];

  // A flagged result carries at least one clipped output.
  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> (attenuation == 32'hFFFFFFFF || phase_constant == 32'hFFFFFFFF))
    else $error("saturated set without a clipped output");

  // A zero factor gives a zero result at the output.
  a_zero_factor: assert property (@(posedge clk) disable iff (rst)
    vld[V8] && !nz8 |-> ##(LAT-1-V8) (done && attenuation == '0 && phase_constant == '0))
    else $error("zero factor did not give a zero result");

  // A series factor with non-zero resistance always has a positive magnitude.
  a_vec_mag: assert property (@(posedge clk) disable iff (rst)
    vld[5+N] && !vside[N].zr |-> (!vz_c[N].x[lpc_pkg::CW-1] && vz_c[N].x != '0))
    else $error("series magnitude not positive");

endmodule

FILE: tb/line_propagation_constant_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and configuration channels of the propagation
// constant block, predicts every result and compares it with what comes out.
module line_propagation_constant_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [31:0]                   frequency_hz,
  input  logic [31:0]                   series_resistance,
  input  logic [31:0]                   extra_reactance,
  input  logic                          done,
  input  logic [31:0]                   attenuation,
  input  logic [31:0]                   phase_constant,
  input  logic                          saturated,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            errors,
  output int                            pending
);
  import lpc_pkg::*;

  typedef struct packed {
    logic [31:0] attenuation;
    logic [31:0] phase_constant;
    logic        saturated;
  } gamma_result_t;

  localparam longint ARCTAN_Q30 [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000};

  logic [31:0] inductance;
  logic [31:0] capacitance;
  logic [31:0] conductance;
  gamma_result_t expected_results [$];

  // Truncating product with a 32-bit constant, scaled down by 2^(32+sh).
  function automatic logic [63:0] scaled_product(input logic [63:0] p, input logic [31:0] k,
                                                 input int sh);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = (p >> 32) * {32'd0, k};
    lo = {32'd0, p[31:0]} * {32'd0, k};
    return (hi + (lo >> 32)) >> (sh & 31);
  endfunction

  function automatic logic [63:0] square_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC on a normalised pair; returns the scaled magnitude.
  function automatic logic [63:0] polar_of(input logic [63:0] re, input logic [63:0] im,
                                           output int shift, output longint angle);
    logic [63:0] m;
    int len;
    int s;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    m = (re > im) ? re : im;
    len = 0;
    z = 0;
    while (m != 0) begin
      len++;
      m = m >> 1;
    end
    s = len - 30;
    if (s >= 0) begin
      x = longint'(re >> s);
      y = longint'(im >> s);
    end else begin
      x = longint'(re << -s);
      y = longint'(im << -s);
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> (i & 31);
      dy = x >>> (i & 31);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q30[i & 31];
      end else begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q30[i & 31];
      end
    end
    shift = s;
    angle = (re == 0) ? longint'(HALF_PI_Q30) : z;
    return (x > 0) ? 64'(x) : 64'd0;
  endfunction

  function automatic logic [31:0] clip_word(input longint v, inout logic sat);
    if (v <= 0) return '0;
    if (v > longint'(64'hFFFF_FFFF)) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic gamma_result_t propagation_predict(input logic [31:0] f,
                                                        input logic [31:0] r,
                                                        input logic [31:0] xi);
    logic [63:0] reactance;
    logic [63:0] susceptance;
    logic [63:0] mag_series;
    logic [63:0] mag_shunt;
    logic [63:0] mm;
    logic [63:0] gamma;
    int sz;
    int sy;
    int e;
    int h;
    longint ang_series;
    longint ang_shunt;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    logic sat;
    gamma_result_t res;
    sat = 1'b0;
    gamma = '0;
    reactance = scaled_product({32'd0, f} * {32'd0, inductance}, PI_Q30, 21) + {32'd0, xi};
    susceptance = scaled_product({32'd0, f} * {32'd0, capacitance}, PI_Q30, 13);
    mag_series = polar_of({32'd0, r}, reactance, sz, ang_series);
    mag_shunt = polar_of({32'd0, conductance}, susceptance, sy, ang_shunt);
    if (mag_series != 0 && mag_shunt != 0) begin
      mm = scaled_product(mag_series * mag_shunt, INV_K2, 0);
      e = sz + sy - 24;
      if (e & 1) begin
        mm = mm << 1;
        e -= 1;
      end
      h = e / 2;
      gamma = square_root(mm);
      if (h >= 0) gamma = gamma << h;
      else if (-h < 64) gamma = gamma >> -h;
      else gamma = '0;
      if (gamma > 64'(MAX_GAMMA)) gamma = 64'(MAX_GAMMA);
    end
    // Rotate the magnitude through the mean of the two angles.
    x = longint'(scaled_product(gamma, INV_K, 0));
    y = 0;
    z = (ang_series + ang_shunt) >>> 1;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> (i & 31);
      dy = x >>> (i & 31);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q30[i & 31];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q30[i & 31];
      end
    end
    res.attenuation = clip_word(x, sat);
    res.phase_constant = clip_word(y, sat);
    res.saturated = sat;
    return res;
  endfunction

  assign pending = expected_results.size();

  // Register writes, accepted commands and results, all sampled at the rising edge.
  always @(posedge clk) begin
    gamma_result_t want;
    if (rst) begin
      inductance = '0;
      capacitance = '0;
      conductance = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INDUCTANCE:  inductance = cfg_data;
          REG_CAPACITANCE: capacitance = cfg_data;
          REG_CONDUCTANCE: conductance = cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (attenuation !== want.attenuation) begin
            $error("attenuation: expected %0d, got %0d", want.attenuation, attenuation);
            errors++;
          end
          if (phase_constant !== want.phase_constant) begin
            $error("phase_constant: expected %0d, got %0d", want.phase_constant,
                   phase_constant);
            errors++;
          end
          if (saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, saturated);
            errors++;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(
          propagation_predict(frequency_hz, series_resistance, extra_reactance));
    end
  end

  initial errors = 0;

endmodule

FILE: tb/line_propagation_constant_tb.sv
`timescale 1ns / 1ps

module line_propagation_constant_tb;
  import lpc_pkg::*;

  // Index past the last register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int DRAIN_CYCLES = 46 + 2 * CORDIC_STAGES + 20;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [31:0]          frequency_hz;
  logic [31:0]          series_resistance;
  logic [31:0]          extra_reactance;
  logic                 done;
  logic [31:0]          attenuation;
  logic [31:0]          phase_constant;
  logic                 saturated;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   errors;
  int                   pending;
  bit                   quiet;

  line_propagation_constant dut (.*);

  line_propagation_constant_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Biased word: zero, all ones, small, shifted down or fully random.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 255);
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_line(input logic [31:0] l, input logic [31:0] c, input logic [31:0] g);
    write_register(REG_INDUCTANCE, l);
    write_register(REG_CAPACITANCE, c);
    write_register(REG_CONDUCTANCE, g);
  endtask

  // Presents one command transaction, held until the block takes it.
  task automatic send_point(input logic [31:0] f, input logic [31:0] r, input logic [31:0] x);
    @(negedge clk);
    start <= 1'b1;
    frequency_hz <= f;
    series_resistance <= r;
    extra_reactance <= x;
    while (busy) @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 10) - 1) @(negedge clk);
    end
  endtask

  // Lets the pipeline empty before the registers are touched again.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic directed_points();
    send_point('0, '0, '0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'd1_000_000, '0, 32'd65536);
    send_point(32'd1_000_000, 32'd65536, '0);
    send_point('0, 32'd65536, '0);
    send_point(32'hFFFF_FFFF, '0, '0);
    send_point(32'd50, 32'hFFFF_FFFF, 32'd1);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    quiet = 1'b0;
    frequency_hz = '0;
    series_resistance = '0;
    extra_reactance = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_INDUCTANCE;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed points: reset values, a typical cable, all-ones, zero conductance.
    directed_points();
    drain();
    set_line(32'd275_000, 32'd7_200_000, 32'd100);
    directed_points();
    drain();
    set_line(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    directed_points();
    drain();
    set_line(32'd275_000, 32'd7_200_000, '0);
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    directed_points();

    // Random sweeps, each under its own line setting; no idling in the last.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      quiet = (p == RANDOM_PHASES - 1);
      set_line(pick_word(), pick_word(), pick_word());
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_point(pick_word(), pick_word(), pick_word());
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
